[sv/isc_pkg.sv]
// Shared types, constants and helper functions for the IMU sample calibration core.
// No dependencies; the design modules and the bench files import this package.
package isc_pkg;

   localparam int NUM_LANES  = 6;
   localparam int QUOT_W     = 16;
   localparam int DIV_W      = 15;
   localparam int PROD_W     = 31;
   localparam int NUM_STAGES = 2 + QUOT_W + 1;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_MAG_CAL_EN   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ACCEL_CAL_EN = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAG_OFFSETS  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MAG_RANGES   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ACCEL_RANGES = 3'd4;

   typedef struct packed {
      logic        mag_cal_en;
      logic        accel_cal_en;
      logic [47:0] mag_offsets;
      logic [47:0] mag_ranges;
      logic [47:0] accel_ranges;
   } isc_cfg_type;

   typedef struct packed {
      logic [DIV_W-1:0]  rem;
      logic [QUOT_W-1:0] qd;
      logic [DIV_W-1:0]  div;
      logic              ovf;
      logic              neg;
   } isc_cell_type;

   function automatic logic [QUOT_W-1:0] sat_quot(logic [QUOT_W-1:0] q, logic ovf,
                                                  logic neg);
      logic [QUOT_W-1:0] res;
      if (!neg) begin
         res = (ovf || q[QUOT_W-1]) ? 16'h7FFF : q;
      end else begin
         res = (ovf || (q > 16'h8000)) ? 16'h8000 : (~q + 16'd1);
      end
      return res;
   endfunction

endpackage

[sv/isc_req_if.sv]
// Request channel carrying one raw magnetometer and one raw accelerometer triple.
// No dependencies.
interface isc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] raw_mag_x;
   logic signed [15:0] raw_mag_y;
   logic signed [15:0] raw_mag_z;
   logic signed [15:0] raw_accel_x;
   logic signed [15:0] raw_accel_y;
   logic signed [15:0] raw_accel_z;

   modport source (output valid, output raw_mag_x, output raw_mag_y, output raw_mag_z,
                   output raw_accel_x, output raw_accel_y, output raw_accel_z,
                   input ready);
   modport sink (input valid, input raw_mag_x, input raw_mag_y, input raw_mag_z,
                 input raw_accel_x, input raw_accel_y, input raw_accel_z,
                 output ready);
endinterface

[sv/isc_rsp_if.sv]
// Response channel carrying the calibrated magnetometer and accelerometer triples.
// No dependencies.
interface isc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] cal_mag_x;
   logic signed [15:0] cal_mag_y;
   logic signed [15:0] cal_mag_z;
   logic signed [15:0] cal_accel_x;
   logic signed [15:0] cal_accel_y;
   logic signed [15:0] cal_accel_z;

   modport source (output valid, output cal_mag_x, output cal_mag_y, output cal_mag_z,
                   output cal_accel_x, output cal_accel_y, output cal_accel_z,
                   input ready);
   modport sink (input valid, input cal_mag_x, input cal_mag_y, input cal_mag_z,
                 input cal_accel_x, input cal_accel_y, input cal_accel_z,
                 output ready);
endinterface

[sv/imu_sample_calibration_core.sv]
// IMU sample calibration core: takes one request per clock while the pipeline is not
// stalled and returns each result through two front-end stages, a chain of 16 division
// cells per axis and one output register; throughput is set by the fully pipelined cell
// chain, and a stalled response only holds the pipeline once every stage is occupied.
// Depends on isc_pkg, isc_req_if, isc_rsp_if, isc_csr, isc_lane_front, isc_div_cell.
module imu_sample_calibration_core #(
   parameter int MAG_FULL_SCALE   = 4096,
   parameter int ACCEL_FULL_SCALE = 32000
) (
   input  logic                            clock,
   input  logic                            reset,
   isc_req_if.sink                         req,
   isc_rsp_if.source                       rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [isc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [isc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [isc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import isc_pkg::*;

   localparam logic [DIV_W-1:0] MAG_FS   = DIV_W'(MAG_FULL_SCALE);
   localparam logic [DIV_W-1:0] ACCEL_FS = DIV_W'(ACCEL_FULL_SCALE);

   isc_cfg_type        cfg;
   logic               valid_ff [NUM_STAGES];
   logic               valid_in [NUM_STAGES];
   logic [NUM_STAGES:0] stage_en;

   logic signed [15:0] lane_raw [NUM_LANES];
   logic signed [15:0] lane_off [NUM_LANES];
   logic signed [15:0] lane_rng [NUM_LANES];
   logic [DIV_W-1:0]   lane_fs  [NUM_LANES];
   logic               lane_cal [NUM_LANES];
   logic               lane_inv [NUM_LANES];

   isc_cell_type       cell_bus [NUM_LANES][QUOT_W+1];
   logic [QUOT_W-1:0]  res_ff   [NUM_LANES];
   logic [QUOT_W-1:0]  res_in   [NUM_LANES];

   isc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_comb begin
      lane_raw[0] = req.raw_mag_y;
      lane_off[0] = cfg.mag_offsets[31:16];
      lane_rng[0] = cfg.mag_ranges[31:16];
      lane_raw[1] = req.raw_mag_x;
      lane_off[1] = cfg.mag_offsets[15:0];
      lane_rng[1] = cfg.mag_ranges[15:0];
      lane_raw[2] = req.raw_mag_z;
      lane_off[2] = cfg.mag_offsets[47:32];
      lane_rng[2] = cfg.mag_ranges[47:32];
      lane_raw[3] = req.raw_accel_x;
      lane_off[3] = 16'sd0;
      lane_rng[3] = cfg.accel_ranges[15:0];
      lane_raw[4] = req.raw_accel_y;
      lane_off[4] = 16'sd0;
      lane_rng[4] = cfg.accel_ranges[31:16];
      lane_raw[5] = req.raw_accel_z;
      lane_off[5] = 16'sd0;
      lane_rng[5] = cfg.accel_ranges[47:32];
      for (int l = 0; l < NUM_LANES; l++) begin
         lane_fs[l]  = (l < 3) ? MAG_FS : ACCEL_FS;
         lane_cal[l] = (l < 3) ? cfg.mag_cal_en : cfg.accel_cal_en;
         lane_inv[l] = (l == 1) || (l == 3);
      end
   end

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      stage_en[NUM_STAGES] = rsp.ready;
      for (int s = NUM_STAGES - 1; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
      valid_in[0] = stage_en[0] ? req.valid : valid_ff[0];
      for (int s = 1; s < NUM_STAGES; s++) begin
         valid_in[s] = stage_en[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   assign req.ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      isc_lane_front u_front (
         .clock      (clock),
         .en_a       (stage_en[0]),
         .en_b       (stage_en[1]),
         .raw        (lane_raw[l]),
         .offset     (lane_off[l]),
         .range      (lane_rng[l]),
         .full_scale (lane_fs[l]),
         .cal_en     (lane_cal[l]),
         .invert     (lane_inv[l]),
         .cell_out   (cell_bus[l][0])
      );

      for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
         isc_div_cell u_cell (
            .clock    (clock),
            .en       (stage_en[2+k]),
            .cell_in  (cell_bus[l][k]),
            .cell_out (cell_bus[l][k+1])
         );
      end

      assign res_in[l] = sat_quot(cell_bus[l][QUOT_W].qd, cell_bus[l][QUOT_W].ovf,
                                  cell_bus[l][QUOT_W].neg);

      always_ff @(posedge clock) begin
         if (stage_en[NUM_STAGES-1]) begin
            res_ff[l] <= res_in[l];
         end
      end
   end

   assign rsp.valid       = valid_ff[NUM_STAGES-1];
   assign rsp.cal_mag_x   = res_ff[0];
   assign rsp.cal_mag_y   = res_ff[1];
   assign rsp.cal_mag_z   = res_ff[2];
   assign rsp.cal_accel_x = res_ff[3];
   assign rsp.cal_accel_y = res_ff[4];
   assign rsp.cal_accel_z = res_ff[5];
endmodule

[sv/isc_csr.sv]
// APB-style register file holding the calibration enables, offsets and ranges.
// Depends on isc_pkg.
module isc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [isc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [isc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [isc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output isc_pkg::isc_cfg_type            cfg
);
   import isc_pkg::*;

   isc_cfg_type           cfg_ff;
   isc_cfg_type           cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MAG_CAL_EN:   cfg_in.mag_cal_en   = pwdata[0];
            REG_ACCEL_CAL_EN: cfg_in.accel_cal_en = pwdata[0];
            REG_MAG_OFFSETS:  cfg_in.mag_offsets  = pwdata[47:0];
            REG_MAG_RANGES:   cfg_in.mag_ranges   = pwdata[47:0];
            REG_ACCEL_RANGES: cfg_in.accel_ranges = pwdata[47:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MAG_CAL_EN:   prdata = {63'd0, cfg_ff.mag_cal_en};
         REG_ACCEL_CAL_EN: prdata = {63'd0, cfg_ff.accel_cal_en};
         REG_MAG_OFFSETS:  prdata = {16'd0, cfg_ff.mag_offsets};
         REG_MAG_RANGES:   prdata = {16'd0, cfg_ff.mag_ranges};
         REG_ACCEL_RANGES: prdata = {16'd0, cfg_ff.accel_ranges};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

[sv/isc_lane_front.sv]
// Front end of one calibration lane: offset and range clamping, magnitude, and the
// full-scale multiply, in two register stages. Depends on isc_pkg.
module isc_lane_front (
   input  logic                              clock,
   input  logic                              en_a,
   input  logic                              en_b,
   input  logic signed [15:0]                raw,
   input  logic signed [15:0]                offset,
   input  logic signed [15:0]                range,
   input  logic [isc_pkg::DIV_W-1:0]         full_scale,
   input  logic                              cal_en,
   input  logic                              invert,
   output isc_pkg::isc_cell_type             cell_out
);
   import isc_pkg::*;

   logic signed [16:0] fs_s;
   logic signed [16:0] off_ext;
   logic signed [16:0] off_cl;
   logic signed [17:0] val;
   logic signed [17:0] val_abs;
   logic [DIV_W-1:0]   rng_cl;
   logic [DIV_W-1:0]   mult;
   logic [PROD_W-1:0]  prod;

   logic [QUOT_W-1:0]  mag_a_ff, mag_a_in;
   logic [DIV_W-1:0]   rng_a_ff, rng_a_in;
   logic               neg_a_ff, neg_a_in;
   logic               cal_a_ff, cal_a_in;
   logic [PROD_W-1:0]  prod_b_ff, prod_b_in;
   logic [DIV_W-1:0]   rng_b_ff, rng_b_in;
   logic               neg_b_ff, neg_b_in;

   always_comb begin
      fs_s    = signed'({2'b00, full_scale});
      off_ext = {offset[15], offset};
      if (off_ext > fs_s) begin
         off_cl = fs_s;
      end else if (off_ext < -fs_s) begin
         off_cl = -fs_s;
      end else begin
         off_cl = off_ext;
      end
      if (cal_en) begin
         val = {{2{raw[15]}}, raw} - {off_cl[16], off_cl};
      end else begin
         val = {{2{raw[15]}}, raw};
      end
      val_abs = val[17] ? -val : val;
      if (range[15] || (range == 16'sd0)) begin
         rng_cl = 15'd1;
      end else if (range[14:0] > full_scale) begin
         rng_cl = full_scale;
      end else begin
         rng_cl = range[14:0];
      end
      mag_a_in = val_abs[15:0];
      rng_a_in = cal_en ? rng_cl : 15'd1;
      neg_a_in = val[17] ^ invert;
      cal_a_in = cal_en;
   end

   always_comb begin
      mult      = cal_a_ff ? full_scale : 15'd1;
      prod      = {15'd0, mag_a_ff} * {16'd0, mult};
      prod_b_in = prod;
      rng_b_in  = rng_a_ff;
      neg_b_in  = neg_a_ff;
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         mag_a_ff <= mag_a_in;
         rng_a_ff <= rng_a_in;
         neg_a_ff <= neg_a_in;
         cal_a_ff <= cal_a_in;
      end
      if (en_b) begin
         prod_b_ff <= prod_b_in;
         rng_b_ff  <= rng_b_in;
         neg_b_ff  <= neg_b_in;
      end
   end

   always_comb begin
      cell_out.rem = prod_b_ff[PROD_W-1:QUOT_W];
      cell_out.qd  = prod_b_ff[QUOT_W-1:0];
      cell_out.div = rng_b_ff;
      cell_out.ovf = prod_b_ff[PROD_W-1:QUOT_W] >= rng_b_ff;
      cell_out.neg = neg_b_ff;
   end
endmodule

[sv/isc_div_cell.sv]
// One restoring-division cell: retires one quotient bit per pass and hands the
// partial remainder and shifted dividend to its neighbor. Depends on isc_pkg.
module isc_div_cell (
   input  logic                  clock,
   input  logic                  en,
   input  isc_pkg::isc_cell_type cell_in,
   output isc_pkg::isc_cell_type cell_out
);
   import isc_pkg::*;

   isc_cell_type      cell_ff;
   isc_cell_type      cell_nxt_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              take;

   always_comb begin
      trial       = {cell_in.rem, cell_in.qd[QUOT_W-1]};
      diff        = trial - {1'b0, cell_in.div};
      take        = trial >= {1'b0, cell_in.div};
      cell_nxt_in = cell_in;
      cell_nxt_in.rem = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cell_nxt_in.qd  = {cell_in.qd[QUOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_nxt_in;
      end
   end

   assign cell_out = cell_ff;
endmodule

[bench/isc_calibration_checker.sv]
// Scoreboard for the IMU sample calibration core: follows register writes on the CSR port,
// predicts each calibrated result from the accepted requests and checks the response channel.
// Depends on isc_pkg, isc_req_if and isc_rsp_if.
module isc_calibration_checker #(
   parameter int MAG_FULL_SCALE   = 4096,
   parameter int ACCEL_FULL_SCALE = 32000
) (
   input  logic                           clock,
   input  logic                           reset,
   isc_req_if                             req,
   isc_rsp_if                             rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [isc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [isc_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             mismatches,
   output int                             outstanding
);
   import isc_pkg::*;

   typedef struct packed {
      logic signed [15:0] mag_x;
      logic signed [15:0] mag_y;
      logic signed [15:0] mag_z;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } cal_sample_type;

   isc_cfg_type cfg;
   cal_sample_type expected_samples [$];

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic signed [15:0] saturate(longint v);
      return 16'(clip(v, -32768, 32767));
   endfunction

   function automatic longint axis_field(logic [47:0] fields, int axis);
      logic signed [15:0] f;
      f = fields[16*axis +: 16];
      return longint'(f);
   endfunction

   function automatic longint rescale(longint value, longint range_field, longint full);
      longint divisor;
      divisor = clip(range_field, 1, full);
      return (value * full) / divisor;
   endfunction

   function automatic longint mag_corrected(longint raw, int axis);
      longint offset;
      offset = clip(axis_field(cfg.mag_offsets, axis), -MAG_FULL_SCALE, MAG_FULL_SCALE);
      return rescale(raw - offset, axis_field(cfg.mag_ranges, axis), MAG_FULL_SCALE);
   endfunction

   function automatic cal_sample_type calibrate(longint mx, longint my, longint mz,
                                                longint ax, longint ay, longint az);
      cal_sample_type r;
      if (cfg.mag_cal_en) begin
         r.mag_x = saturate(mag_corrected(my, 1));
         r.mag_y = saturate(-mag_corrected(mx, 0));
         r.mag_z = saturate(mag_corrected(mz, 2));
      end else begin
         r.mag_x = saturate(my);
         r.mag_y = saturate(-mx);
         r.mag_z = saturate(mz);
      end
      if (cfg.accel_cal_en) begin
         r.accel_x = saturate(-rescale(ax, axis_field(cfg.accel_ranges, 0), ACCEL_FULL_SCALE));
         r.accel_y = saturate(rescale(ay, axis_field(cfg.accel_ranges, 1), ACCEL_FULL_SCALE));
         r.accel_z = saturate(rescale(az, axis_field(cfg.accel_ranges, 2), ACCEL_FULL_SCALE));
      end else begin
         r.accel_x = saturate(-ax);
         r.accel_y = saturate(ay);
         r.accel_z = saturate(az);
      end
      return r;
   endfunction

   function automatic int compare_sample(cal_sample_type want, cal_sample_type got);
      logic [5:0][15:0] w;
      logic [5:0][15:0] g;
      string names [6];
      int bad;
      names = '{"cal_accel_z", "cal_accel_y", "cal_accel_x",
                "cal_mag_z", "cal_mag_y", "cal_mag_x"};
      w = want;
      g = got;
      bad = 0;
      for (int i = 0; i < 6; i++) begin
         if (g[i] !== w[i]) begin
            $display("%0t: %s expected %0d, got %0d", $time, names[i],
                     $signed(w[i]), $signed(g[i]));
            bad++;
         end
      end
      return bad;
   endfunction

   always @(posedge clock) begin
      cal_sample_type got;
      int bad;
      bad = 0;
      if (reset) begin
         cfg <= '0;
         expected_samples.delete();
         mismatches <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1 -: REG_IDX_W])
               REG_MAG_CAL_EN:   cfg.mag_cal_en   <= pwdata[0];
               REG_ACCEL_CAL_EN: cfg.accel_cal_en <= pwdata[0];
               REG_MAG_OFFSETS:  cfg.mag_offsets  <= pwdata[47:0];
               REG_MAG_RANGES:   cfg.mag_ranges   <= pwdata[47:0];
               REG_ACCEL_RANGES: cfg.accel_ranges <= pwdata[47:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            expected_samples.push_back(calibrate(req.raw_mag_x, req.raw_mag_y, req.raw_mag_z,
                                                 req.raw_accel_x, req.raw_accel_y,
                                                 req.raw_accel_z));
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.cal_mag_x, rsp.cal_mag_y, rsp.cal_mag_z,
                    rsp.cal_accel_x, rsp.cal_accel_y, rsp.cal_accel_z};
            if (expected_samples.size() == 0) begin
               $display("%0t: response with no request pending, got %h", $time, got);
               bad = 1;
            end else begin
               bad = compare_sample(expected_samples.pop_front(), got);
            end
         end
         mismatches <= mismatches + bad;
      end
      outstanding <= expected_samples.size();
   end

endmodule

[bench/tb_imu_sample_calibration_core.sv]
// Testbench top for the IMU sample calibration core: directed and random requests with
// random idling on both channels, register settings changed between phases.
// Depends on isc_pkg, isc_req_if, isc_rsp_if, isc_calibration_checker and the core.
module tb_imu_sample_calibration_core;
   import isc_pkg::*;

   localparam int MAG_FS       = 4096;
   localparam int ACCEL_FS     = 32000;
   localparam int DRAIN_CYCLES = NUM_STAGES + 6;
   localparam int PHASE_ITEMS  = 300;
   localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_ACCEL_RANGES + 1'b1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatches;
   int                    outstanding;
   int                    gap_pct;
   int                    stall_pct;
   int                    stall_left;
   int                    gap_plan [6]   = '{20, 0, 50, 10, 30, 0};
   int                    stall_plan [6] = '{20, 60, 0, 10, 40, 0};

   isc_req_if req ();
   isc_rsp_if rsp ();

   imu_sample_calibration_core #(
      .MAG_FULL_SCALE  (MAG_FS),
      .ACCEL_FULL_SCALE(ACCEL_FS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   isc_calibration_checker #(
      .MAG_FULL_SCALE  (MAG_FS),
      .ACCEL_FULL_SCALE(ACCEL_FS)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
         rsp.ready <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   initial begin
      #(12 * 200000);
      $display("tb_imu_sample_calibration_core: FAIL");
      $finish;
   end

   function automatic logic [15:0] random_raw();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 400)) - 200);
         3: return 16'(int'($urandom_range(0, 20000)) - 10000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_offset();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'(MAG_FS);
         2: return 16'(-MAG_FS);
         default: return 16'(int'($urandom_range(0, 2 * MAG_FS)) - MAG_FS);
      endcase
   endfunction

   function automatic logic [15:0] random_range(int full);
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'(0);
         2: return 16'(full);
         3: return 16'(full + 1);
         4: return 16'($urandom_range(1, 8));
         5: return 16'(-int'($urandom_range(1, 32768)));
         default: return 16'($urandom_range(1, full));
      endcase
   endfunction

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(input logic [15:0] mx, input logic [15:0] my,
                               input logic [15:0] mz, input logic [15:0] ax,
                               input logic [15:0] ay, input logic [15:0] az);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.raw_mag_x <= mx;
      req.raw_mag_y <= my;
      req.raw_mag_z <= mz;
      req.raw_accel_x <= ax;
      req.raw_accel_y <= ay;
      req.raw_accel_z <= az;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_random_config(input int phase);
      logic [CSR_DATA_W-1:0] v;
      v = {$urandom, $urandom};
      v[0] = (phase != 0 && phase != 4);
      write_reg(REG_MAG_CAL_EN, v);
      v = {$urandom, $urandom};
      v[0] = (phase != 1 && phase != 4);
      write_reg(REG_ACCEL_CAL_EN, v);
      write_reg(REG_MAG_OFFSETS, {16'($urandom), random_offset(), random_offset(),
                                  random_offset()});
      write_reg(REG_MAG_RANGES, {16'($urandom), random_range(MAG_FS), random_range(MAG_FS),
                                 random_range(MAG_FS)});
      write_reg(REG_ACCEL_RANGES, {16'($urandom), random_range(ACCEL_FS),
                                   random_range(ACCEL_FS), random_range(ACCEL_FS)});
      if ($urandom_range(0, 1) == 1) begin
         write_reg(REG_SPARE, {$urandom, $urandom});
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req.valid = 1'b0;
      req.raw_mag_x = '0;
      req.raw_mag_y = '0;
      req.raw_mag_z = '0;
      req.raw_accel_x = '0;
      req.raw_accel_y = '0;
      req.raw_accel_z = '0;
      gap_pct = 0;
      stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Calibration off after reset: only the axis remap and sign changes apply.
      send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF);
      drain();

      // Calibration on with the reset ranges of zero, which act as one.
      write_reg(REG_MAG_CAL_EN, 64'd1);
      write_reg(REG_ACCEL_CAL_EN, 64'd1);
      send_request(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
      send_request(16'h0008, 16'h0008, 16'h0008, 16'h0008, 16'h0008, 16'h0008);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      drain();

      // Offsets and ranges outside their limits, a full-scale range and truncating divisors.
      write_reg(REG_MAG_OFFSETS, {16'hA5A5, 16'hF000, 16'h7FFF, 16'h8000});
      write_reg(REG_MAG_RANGES, {16'h5A5A, 16'd3000, 16'h7FFF, 16'hFFFB});
      write_reg(REG_ACCEL_RANGES, {16'hFFFF, 16'd3, 16'd32001, 16'd32000});
      write_reg(REG_SPARE, '1);
      send_request(16'h8000, 16'h7FFF, 16'hFFFB, 16'h8000, 16'h7FFF, 16'hFFF9);
      send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(16'd100, 16'hFF9C, 16'd2999, 16'd7, 16'hFFF9, 16'h0001);
      send_request(16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         load_random_config(phase);
         gap_pct = gap_plan[phase];
         stall_pct <= stall_plan[phase];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 1 && i == PHASE_ITEMS / 2) begin
               drain();
            end
            send_request(random_raw(), random_raw(), random_raw(),
                         random_raw(), random_raw(), random_raw());
         end
         drain();
      end

      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_imu_sample_calibration_core: PASS");
      end else begin
         $display("tb_imu_sample_calibration_core: FAIL");
      end
      $finish;
   end

endmodule

[imu_sample_calibration_core.f]
sv/isc_pkg.sv
sv/isc_req_if.sv
sv/isc_rsp_if.sv
sv/isc_csr.sv
sv/isc_lane_front.sv
sv/isc_div_cell.sv
sv/imu_sample_calibration_core.sv
bench/isc_calibration_checker.sv
bench/tb_imu_sample_calibration_core.sv
